>>> sv/dtpq_pkg.sv
package dtpq_pkg;

	localparam int LANES = 8;
	localparam int WORD_W = 16;
	localparam logic [1:0] CRIT_LIMIT = 2'd3;

	localparam logic [1:0] CFG_GROUP_SIZE = 2'd0;
	localparam logic [1:0] CFG_DELAY_TICKS = 2'd1;
	localparam logic [1:0] CFG_UPPER_CRIT = 2'd2;

	localparam logic [2:0] ST_OFF = 3'd0;
	localparam logic [2:0] ST_DELAYING = 3'd1;
	localparam logic [2:0] ST_ALL_FAILED = 3'd2;
	localparam logic [2:0] ST_PUBLISHED = 3'd3;
	localparam logic [2:0] ST_CRIT_PENDING = 3'd4;

	localparam logic [3:0] GROUP_SIZE_RST = 4'd1;
	localparam logic [7:0] DELAY_TICKS_RST = 8'd0;
	localparam logic [9:0] UPPER_CRIT_RST = 10'd512;

	typedef struct packed {
		logic        power_on;
		logic        owner_present;
		logic [63:0] words_lanes_low;
		logic [63:0] words_lanes_high;
		logic [7:0]  read_ok_mask;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       available;
		logic       updated;
		logic [8:0] temperature;
		logic [1:0] critical_hits;
	} result_t;

	typedef struct packed {
		logic       any_ok;
		logic [8:0] best;
	} lane_max_t;

	// The low byte of the word carries the upper temperature bits.
	function automatic logic [8:0] lane_degrees(input logic [WORD_W-1:0] word);
		logic [12:0] raw;
		raw = {word[4:0], word[15:8]};
		return raw[12:4];
	endfunction

endpackage

>>> sv/dtpq_lane_max.sv
module dtpq_lane_max (
	input  logic [63:0]          words_lanes_low,
	input  logic [63:0]          words_lanes_high,
	input  logic [7:0]           read_ok_mask,
	input  logic [3:0]           group_size,
	output dtpq_pkg::lane_max_t  lane_max
);
	import dtpq_pkg::*;

	logic [2*64-1:0] words;

	assign words = {words_lanes_high, words_lanes_low};

	always_comb begin
		logic [8:0] d;
		lane_max = '0;
		d = '0;
		for (int i = 0; i < LANES; i++) begin
			if (read_ok_mask[i] && (4'(i) < group_size)) begin
				d = lane_degrees(words[i*WORD_W +: WORD_W]);
				if (d >= lane_max.best) begin
					lane_max.best = d;
				end
				lane_max.any_ok = 1'b1;
			end
		end
	end

endmodule

>>> sv/dimm_temp_poll_qualifier.sv
// Qualifies DIMM temperature poll ticks. Each beat on the item channel is one
// poll tick with the power and owner flags, up to eight raw sensor words and
// their read success mask. Each tick yields exactly one beat on the result
// channel with the status, availability, publish flag, last published
// temperature and the critical hit count.
// Both channels use valid/ready. A tick is captured in an input register and
// evaluated from there into the result register, which offers it as the
// result beat. One tick per cycle is sustained while the receiver takes
// results; the lane decode and maximum sit between those two registers.
// When the receiver stalls, the result register holds its beat and an empty
// input register still takes one more tick; after that item_ready drops
// until the result is taken.
// The configuration port writes group_size, delay_ticks and upper_critical
// by index. The asynchronous reset empties both registers, clears the delay
// count, hit count, published temperature and availability and restores the
// configuration defaults.
module dimm_temp_poll_qualifier (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  dtpq_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output dtpq_pkg::result_t result,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [9:0]        cfg_data
);
	import dtpq_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       res_valid_q;
	result_t    res_q;

	logic [3:0] group_size_q;
	logic [7:0] delay_ticks_q;
	logic [9:0] upper_crit_q;

	logic [7:0] delay_count_q;
	logic [1:0] crit_count_q;
	logic [8:0] temp_q;
	logic       avail_q;

	logic       advance;
	lane_max_t  lane_max;
	logic [7:0] delay_count_d;
	logic [1:0] crit_count_d;
	logic [8:0] temp_d;
	logic       avail_d;
	logic       updated_d;
	logic [2:0] status_d;
	logic       hot;

	assign advance = valid_s1 && (!res_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign result_valid = res_valid_q;
	assign result = res_q;

	dtpq_lane_max u_lane_max (
		.words_lanes_low  (item_s1.words_lanes_low),
		.words_lanes_high (item_s1.words_lanes_high),
		.read_ok_mask     (item_s1.read_ok_mask),
		.group_size       (group_size_q),
		.lane_max         (lane_max)
	);

	assign hot = {1'b0, lane_max.best} >= upper_crit_q;

	always_comb begin
		delay_count_d = delay_count_q;
		crit_count_d = crit_count_q;
		temp_d = temp_q;
		avail_d = avail_q;
		updated_d = 1'b0;
		status_d = ST_OFF;
		if (!item_s1.power_on || !item_s1.owner_present) begin
			avail_d = 1'b0;
			delay_count_d = '0;
			status_d = ST_OFF;
		end else if (delay_count_q < delay_ticks_q) begin
			avail_d = 1'b0;
			delay_count_d = delay_count_q + 8'd1;
			status_d = ST_DELAYING;
		end else if (!lane_max.any_ok) begin
			avail_d = 1'b0;
			status_d = ST_ALL_FAILED;
		end else begin
			if (hot) begin
				crit_count_d = (crit_count_q < CRIT_LIMIT) ? crit_count_q + 2'd1 : crit_count_q;
			end else begin
				crit_count_d = '0;
			end
			if (!hot || crit_count_d >= CRIT_LIMIT) begin
				avail_d = 1'b1;
				temp_d = lane_max.best;
				updated_d = 1'b1;
				status_d = ST_PUBLISHED;
			end else begin
				status_d = ST_CRIT_PENDING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_RST;
			delay_ticks_q <= DELAY_TICKS_RST;
			upper_crit_q <= UPPER_CRIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_GROUP_SIZE: group_size_q <= cfg_data[3:0];
				CFG_DELAY_TICKS: delay_ticks_q <= cfg_data[7:0];
				CFG_UPPER_CRIT: upper_crit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			delay_count_q <= '0;
			crit_count_q <= '0;
			temp_q <= '0;
			avail_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				delay_count_q <= delay_count_d;
				crit_count_q <= crit_count_d;
				temp_q <= temp_d;
				avail_q <= avail_d;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (advance) begin
			res_q.status <= status_d;
			res_q.available <= avail_d;
			res_q.updated <= updated_d;
			res_q.temperature <= temp_d;
			res_q.critical_hits <= crit_count_d;
		end
	end

endmodule

>>> sv/dtpq_checker.sv
module dtpq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input dtpq_pkg::result_t result
);
	import dtpq_pkg::*;

	// A stalled result beat must hold.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_updated_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.updated == (result.status == ST_PUBLISHED)))
		else $error("updated flag disagrees with status");

	a_published_avail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_PUBLISHED |-> result.available)
		else $error("published tick without availability");

	a_unavail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_OFF || result.status == ST_DELAYING ||
		result.status == ST_ALL_FAILED) |-> !result.available)
		else $error("sensor available on a tick that cannot publish");

	a_pending_hits: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_CRIT_PENDING |->
		result.critical_hits != 2'd0 && result.critical_hits < CRIT_LIMIT)
		else $error("critical pending with hit count out of range");

endmodule

bind dimm_temp_poll_qualifier dtpq_checker u_dtpq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
